>>> rtl/h2r_pkg.sv
// shared types and constants for the hsv to rgb converter
package h2r_pkg;

  // hue scale: 1/64 degree units
  localparam logic [15:0] HUE_TURN   = 16'd23040;  // 360 degrees
  localparam logic [14:0] HUE_SECTOR = 15'd3840;   // 60 degrees

  // full-scale fraction and the common denominator 255 * 3840
  localparam logic [7:0]  UNIT_FRAC = 8'd255;
  localparam logic [19:0] DEN_QT    = 20'd979200;

  // ceil(2^32 / 3825); exact floor division for numerators below 2^20
  localparam logic [20:0] RECIP_3825 = 21'd1122868;
  localparam int unsigned RECIP_SHIFT = 32;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // 60-degree hue sectors
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } sector_t;

  // classified item handed from front to back
  typedef struct packed {
    sector_t     sector;
    logic [11:0] rem;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [7:0]  alpha;
  } item_t;

endpackage

>>> rtl/h2r_front.sv
// front end: takes a beat, wraps the hue and splits it into sector and remainder
module h2r_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [15:0]    hue,
  input  logic [7:0]     saturation,
  input  logic [7:0]     brightness,
  input  logic [7:0]     alpha_in,
  input  logic           q_full,
  output logic           q_push,
  output h2r_pkg::item_t q_item
);
  import h2r_pkg::*;

  logic        f_valid;
  logic        f_valid_next;
  item_t       f_item;
  logic        accept;
  logic [14:0] hue_w;
  sector_t     sector;
  logic [14:0] base;
  logic [14:0] rem_w;

  assign busy   = f_valid && q_full;
  assign accept = start && !busy;
  assign q_push = f_valid && !q_full;
  assign q_item = f_item;

  // full turn and beyond counts as zero
  assign hue_w = (hue >= HUE_TURN) ? 15'd0 : hue[14:0];

  always_comb begin
    if (hue_w >= 15'(HUE_SECTOR * 5)) begin
      sector = SECT_MAG_RED;
      base   = 15'(HUE_SECTOR * 5);
    end else if (hue_w >= 15'(HUE_SECTOR * 4)) begin
      sector = SECT_BLU_MAG;
      base   = 15'(HUE_SECTOR * 4);
    end else if (hue_w >= 15'(HUE_SECTOR * 3)) begin
      sector = SECT_CYN_BLU;
      base   = 15'(HUE_SECTOR * 3);
    end else if (hue_w >= 15'(HUE_SECTOR * 2)) begin
      sector = SECT_GRN_CYN;
      base   = 15'(HUE_SECTOR * 2);
    end else if (hue_w >= HUE_SECTOR) begin
      sector = SECT_YEL_GRN;
      base   = HUE_SECTOR;
    end else begin
      sector = SECT_RED_YEL;
      base   = 15'd0;
    end
  end

  assign rem_w = hue_w - base;

  always_comb begin
    f_valid_next = f_valid;
    if (accept) begin
      f_valid_next = 1'b1;
    end else if (q_push) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.sector <= sector;
      f_item.rem    <= rem_w[11:0];
      f_item.sat    <= saturation;
      f_item.val    <= brightness;
      f_item.alpha  <= alpha_in;
    end
  end

endmodule

>>> rtl/h2r_queue.sv
// short fifo of classified items between front and back
module h2r_queue #(
  parameter int unsigned DEPTH = h2r_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  h2r_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output h2r_pkg::item_t pop_item,
  output logic           empty
);
  import h2r_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

>>> rtl/h2r_back.sv
// back end: computes p, q and t and routes them to red, green and blue
module h2r_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  output logic           q_pop,
  input  h2r_pkg::item_t q_item,
  output logic           done,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue,
  output logic [7:0]     alpha_out
);
  import h2r_pkg::*;

  // stage 1: s * rem and s * 3840
  logic        v1;
  sector_t     s1_sector;
  logic [19:0] s1_prod;
  logic [19:0] s1_sfull;
  logic [7:0]  s1_sat;
  logic [7:0]  s1_val;
  logic [7:0]  s1_alpha;

  // stage 2: v times the numerators
  logic        v2;
  sector_t     s2_sector;
  logic [27:0] s2_mq;
  logic [27:0] s2_mt;
  logic [15:0] s2_mp;
  logic [7:0]  s2_val;
  logic [7:0]  s2_alpha;

  // stage 3: divided channels
  logic        v3;
  sector_t     s3_sector;
  logic [7:0]  s3_p;
  logic [7:0]  s3_q;
  logic [7:0]  s3_t;
  logic [7:0]  s3_val;
  logic [7:0]  s3_alpha;

  logic [19:0] num_q;
  logic [19:0] num_t;
  logic [7:0]  num_p;
  logic [16:0] p_sum;
  logic [40:0] q_prod;
  logic [40:0] t_prod;
  logic [7:0]  r_sel;
  logic [7:0]  g_sel;
  logic [7:0]  b_sel;

  assign q_pop = !q_empty;

  assign num_q = DEN_QT - s1_prod;
  assign num_t = DEN_QT - s1_sfull + s1_prod;
  assign num_p = UNIT_FRAC - s1_sat;

  // x / 255 for x below 2^16
  assign p_sum = 17'(s2_mp) + 17'(s2_mp[15:8]) + 17'd1;
  // (x >> 8) / 3825 by reciprocal
  assign q_prod = 41'(s2_mq[27:8]) * 41'(RECIP_3825);
  assign t_prod = 41'(s2_mt[27:8]) * 41'(RECIP_3825);

  always_comb begin
    case (s3_sector)
      SECT_RED_YEL: begin r_sel = s3_val; g_sel = s3_t;   b_sel = s3_p;   end
      SECT_YEL_GRN: begin r_sel = s3_q;   g_sel = s3_val; b_sel = s3_p;   end
      SECT_GRN_CYN: begin r_sel = s3_p;   g_sel = s3_val; b_sel = s3_t;   end
      SECT_CYN_BLU: begin r_sel = s3_p;   g_sel = s3_q;   b_sel = s3_val; end
      SECT_BLU_MAG: begin r_sel = s3_t;   g_sel = s3_p;   b_sel = s3_val; end
      default: begin r_sel = s3_val; g_sel = s3_p; b_sel = s3_q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= q_pop;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s1_sector <= q_item.sector;
    s1_prod   <= 20'(q_item.sat) * 20'(q_item.rem);
    s1_sfull  <= 20'(q_item.sat) * 20'(HUE_SECTOR);
    s1_sat    <= q_item.sat;
    s1_val    <= q_item.val;
    s1_alpha  <= q_item.alpha;

    s2_sector <= s1_sector;
    s2_mq     <= 28'(s1_val) * 28'(num_q);
    s2_mt     <= 28'(s1_val) * 28'(num_t);
    s2_mp     <= 16'(s1_val) * 16'(num_p);
    s2_val    <= s1_val;
    s2_alpha  <= s1_alpha;

    s3_sector <= s2_sector;
    s3_p      <= p_sum[15:8];
    s3_q      <= q_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    s3_t      <= t_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    s3_val    <= s2_val;
    s3_alpha  <= s2_alpha;

    red       <= r_sel;
    green     <= g_sel;
    blue      <= b_sel;
    alpha_out <= s3_alpha;
  end

endmodule

>>> rtl/hsv_to_rgb_convert.sv
// top level of the hsv to rgb converter
// A beat is taken at each rising edge where start is high and busy is low;
// the block takes one beat every clock and each beat gives exactly one
// result, in order. The result appears on red, green, blue and alpha_out
// with done high for one cycle. The accept edge loads the front register;
// the beat then passes a slot in the queue, three arithmetic stages and the
// output register. The receiver cannot hold results off, so the back end
// never stalls and the queue drains every cycle; busy only rises if the
// queue fills, which a free-running back end prevents. Hue is wrapped to
// zero at 360 degrees and split into a 60-degree sector and remainder in
// the front; the back forms p = v(1-s), q = v(1-s*f) and t = v(1-s(1-f))
// with truncation and routes them by sector. Alpha passes through. No
// configuration and no state beyond the pipeline.
module hsv_to_rgb_convert #(
  parameter int unsigned QUEUE_DEPTH = h2r_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [15:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  input  logic [7:0] alpha_in,
  output logic       done,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha_out
);
  import h2r_pkg::*;

  // front to queue
  logic  q_push;
  logic  q_full;
  item_t q_in;

  // queue to back
  logic  q_pop;
  logic  q_empty;
  item_t q_out;

  // classify: hue wrap, sector and remainder
  h2r_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .alpha_in   (alpha_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  // decouples the front from the arithmetic pipeline
  h2r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  // arithmetic and channel routing
  h2r_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_out),
    .done      (done),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha_out (alpha_out)
  );

  // every accepted beat comes out with a done pulse
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("result missing after accepted beat");

  // alpha rides along with its own pixel
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 (alpha_out == $past(alpha_in, 6)))
    else $error("alpha does not match its pixel");

  // zero saturation gives gray at the input value
  a_gray: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && saturation == 8'd0) |->
      ##6 (red == $past(brightness, 6) && green == red && blue == red))
    else $error("gray pixel not at brightness");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the hsv to rgb converter
module testbench;
  import h2r_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no beat in or out
  localparam int unsigned SETTLE_CYCLES = 12;  // settle time after the last expected pixel

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;
  logic [7:0]  alpha_in;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha_out;

  rgba_t       pending_rgb[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  hsv_to_rgb_convert u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .alpha_in   (alpha_in),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha_out  (alpha_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // expected color for one pixel; every quotient is truncated toward zero
  function automatic rgba_t hsv_pixel(logic [15:0] h, logic [7:0] s, logic [7:0] v,
                                      logic [7:0] a);
    rgba_t      px;
    bit [63:0]  hw;
    bit [63:0]  frac;
    bit [63:0]  sv;
    bit [63:0]  vv;
    bit [63:0]  den;
    bit [63:0]  p;
    bit [63:0]  q;
    bit [63:0]  t;
    sector_t    sect;
    hw = h;
    sv = s;
    vv = v;
    den = 64'(UNIT_FRAC) * 64'(HUE_SECTOR);
    px.alpha = a;
    if (s == 8'd0) begin
      px.red = v;
      px.green = v;
      px.blue = v;
      return px;
    end
    // a full turn or more wraps to red
    if (hw >= 64'(HUE_TURN)) hw = '0;
    sect = sector_t'(3'(hw / 64'(HUE_SECTOR)));
    frac = hw % 64'(HUE_SECTOR);
    p = (vv * (64'(UNIT_FRAC) - sv)) / 64'(UNIT_FRAC);
    q = (vv * (den - sv * frac)) / den;
    t = (vv * (den - sv * (64'(HUE_SECTOR) - frac))) / den;
    case (sect)
      SECT_RED_YEL: begin px.red = v;        px.green = t[7:0]; px.blue = p[7:0]; end
      SECT_YEL_GRN: begin px.red = q[7:0];   px.green = v;      px.blue = p[7:0]; end
      SECT_GRN_CYN: begin px.red = p[7:0];   px.green = v;      px.blue = t[7:0]; end
      SECT_CYN_BLU: begin px.red = p[7:0];   px.green = q[7:0]; px.blue = v;      end
      SECT_BLU_MAG: begin px.red = t[7:0];   px.green = p[7:0]; px.blue = v;      end
      default:      begin px.red = v;        px.green = p[7:0]; px.blue = q[7:0]; end
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string chan, logic [7:0] want, logic [7:0] got);
    $display("[%0t] %s: expected %0d, got %0d", $time, chan, want, got);
    mismatch_count++;
  endtask

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_pixel(logic [15:0] h, logic [7:0] s, logic [7:0] v, logic [7:0] a);
    start <= 1'b1;
    hue <= h;
    saturation <= s;
    brightness <= v;
    alpha_in <= a;
    do @(posedge clk); while (busy);
    pending_rgb.insert(pending_rgb.size(), hsv_pixel(h, s, v, a));
    @(negedge clk);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_rgb.size() != 0) @(negedge clk);
  endtask

  // mostly in-range hues, some wrapped ones and some fully random words
  task automatic send_random_pixel();
    logic [15:0] h;
    logic [7:0]  s;
    logic [7:0]  v;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 8)       h = 16'($urandom_range(0, 23039));
    else if (pick == 8) h = 16'($urandom_range(23040, 65535));
    else                h = 16'($urandom());
    pick = $urandom_range(0, 9);
    s = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom());
    pick = $urandom_range(0, 9);
    v = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom());
    send_pixel(h, s, v, 8'($urandom()));
  endtask

  // corners: wrap point, sector edges, gray, full and zero channels
  task automatic test_directed();
    send_pixel(16'd0,     8'd255, 8'd255, 8'd0);
    send_pixel(16'd3839,  8'd255, 8'd255, 8'd255);
    send_pixel(16'd3840,  8'd255, 8'd255, 8'd1);
    send_pixel(16'd7679,  8'd200, 8'd255, 8'd128);
    send_pixel(16'd7680,  8'd255, 8'd200, 8'd127);
    send_pixel(16'd11520, 8'd255, 8'd255, 8'd2);
    send_pixel(16'd15360, 8'd255, 8'd255, 8'd4);
    send_pixel(16'd19200, 8'd255, 8'd255, 8'd8);
    send_pixel(16'd23039, 8'd255, 8'd255, 8'd16);
    send_pixel(16'd23040, 8'd255, 8'd255, 8'd32);
    send_pixel(16'd65535, 8'd255, 8'd255, 8'd64);
    send_pixel(16'd65535, 8'd0,   8'd255, 8'd170);
    send_pixel(16'd1920,  8'd0,   8'd77,  8'd85);
    send_pixel(16'd1920,  8'd255, 8'd0,   8'd255);
    send_pixel(16'd5760,  8'd1,   8'd255, 8'd3);
    send_pixel(16'd9600,  8'd128, 8'd255, 8'd5);
    send_pixel(16'd13440, 8'd255, 8'd1,   8'd9);
    send_pixel(16'd17280, 8'd90,  8'd180, 8'd17);
    send_pixel(16'd21120, 8'd255, 8'd128, 8'd33);
    send_pixel(16'd1,     8'd255, 8'd255, 8'd65);
    send_pixel(16'd32768, 8'd128, 8'd128, 8'd129);
    send_pixel(16'd21845, 8'd85,  8'd170, 8'd254);
    idle_gap(1);
  endtask

  // bursts of random length with random gaps, zero gaps included
  task automatic test_random_bursts(int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_random_pixel();
      sent += burst;
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    end
    idle_gap(1);
  endtask

  // sender holds off until every expected pixel is back
  task automatic test_drain_pauses();
    repeat (4) begin
      repeat ($urandom_range(5, 30)) send_random_pixel();
      idle_gap(1);
      wait_drained();
    end
  endtask

  // one long stretch with start held high
  task automatic test_back_to_back(int unsigned n_items);
    repeat (n_items) send_random_pixel();
    idle_gap(1);
  endtask

  // result checker: every done beat is compared with the oldest expectation
  always @(posedge clk) begin
    rgba_t want;
    if (!rst && done) begin
      if (pending_rgb.size() == 0) begin
        $display("[%0t] result beat with no pixel outstanding", $time);
        mismatch_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (red !== want.red)         report_mismatch("red", want.red, red);
        if (green !== want.green)     report_mismatch("green", want.green, green);
        if (blue !== want.blue)       report_mismatch("blue", want.blue, blue);
        if (alpha_out !== want.alpha) report_mismatch("alpha", want.alpha, alpha_out);
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("hsv_to_rgb_convert: mismatch");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    hue = '0;
    saturation = '0;
    brightness = '0;
    alpha_in = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_bursts(1450);
    test_drain_pauses();
    test_back_to_back(350);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_rgb.size() == 0) begin
      $display("hsv_to_rgb_convert: match");
    end else begin
      $display("hsv_to_rgb_convert: mismatch");
    end
    $finish;
  end

endmodule
